### rtl/longest_common_subsequence_defines.svh
// Assertion macros used by the longest common subsequence top module.
`ifndef LONGEST_COMMON_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_COMMON_SUBSEQUENCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lcs_pkg.sv
// Types and constants for the longest common subsequence block.
package lcs_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int CMD_W     = 2;
    localparam int OUT_SYM_W = 8;
    localparam int OUT_LEN_W = 7;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2
    } lcs_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_TB_RD,
        ST_TB_CHK,
        ST_TB_LEFT,
        ST_EMIT_RD,
        ST_EMIT,
        ST_EMPTY
    } lcs_state_t;

    // One result item offered by the engine.
    typedef struct packed {
        logic                 valid;
        logic [OUT_SYM_W-1:0] symbol;
        logic                 has_symbol;
        logic [OUT_LEN_W-1:0] length;
        logic                 last;
    } lcs_emit_t;

endpackage

### rtl/lcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lcs_engine.sv
// Table fill, traceback and result sequencing for the LCS block.
module lcs_engine
    import lcs_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CNT_W = $clog2(MAX_LEN + 1),
    localparam int SYM_W = (SYMBOL_BITS < OUT_SYM_W) ? SYMBOL_BITS : OUT_SYM_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CNT_W-1:0] len_a,
    input  logic [CNT_W-1:0] len_b,
    output logic             s1_re,
    output logic [IDX_W-1:0] s1_raddr,
    input  logic [SYM_W-1:0] s1_rdata,
    output logic             s2_re,
    output logic [IDX_W-1:0] s2_raddr,
    input  logic [SYM_W-1:0] s2_rdata,
    output lcs_emit_t        emit,
    input  logic             emit_ready,
    output logic             done
);

    localparam int TBL_AW = 2 * IDX_W;

    lcs_state_t state_reg, state_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0] up_reg, up_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] diag_reg, diag_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] k_reg, k_next;

    logic              tbl_we, tbl_re;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [CNT_W-1:0]  tbl_wdata, tbl_rdata;
    logic              ans_we, ans_re;
    logic [IDX_W-1:0]  ans_waddr, ans_raddr;
    logic [SYM_W-1:0]  ans_rdata;

    logic [CNT_W-1:0] r_dec, r_dec2, c_dec, c_dec2, pos_dec, k_inc;
    logic [CNT_W-1:0] up_val, left_val, cell_val;
    logic             match, first_row, first_col;

    assign r_dec     = r_reg - 1'b1;
    assign r_dec2    = r_reg - 2'd2;
    assign c_dec     = c_reg - 1'b1;
    assign c_dec2    = c_reg - 2'd2;
    assign pos_dec   = pos_reg - 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign first_row = (r_reg == CNT_W'(1));
    assign first_col = (c_reg == CNT_W'(1));
    assign match     = (s1_rdata == s2_rdata);

    // Row zero and column zero of the table are the zero border, never stored.
    assign up_val   = first_row ? '0 : tbl_rdata;
    assign left_val = first_col ? '0 : tbl_rdata;
    assign cell_val = match ? diag_reg + 1'b1 : ((up_val > left_reg) ? up_val : left_reg);

    lcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (1 << TBL_AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    lcs_ram #(
        .WIDTH (SYM_W),
        .DEPTH (1 << IDX_W)
    ) u_answer (
        .aclk  (aclk),
        .we    (ans_we),
        .waddr (ans_waddr),
        .wdata (s1_rdata),
        .re    (ans_re),
        .raddr (ans_raddr),
        .rdata (ans_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        c_reg     <= c_next;
        up_reg    <= up_next;
        left_reg  <= left_next;
        diag_reg  <= diag_next;
        total_reg <= total_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        up_next    = up_reg;
        left_next  = left_reg;
        diag_next  = diag_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        s1_re      = 1'b0;
        s1_raddr   = r_dec[IDX_W-1:0];
        s2_re      = 1'b0;
        s2_raddr   = c_dec[IDX_W-1:0];
        tbl_we     = 1'b0;
        tbl_waddr  = {r_dec[IDX_W-1:0], c_dec[IDX_W-1:0]};
        tbl_wdata  = cell_val;
        tbl_re     = 1'b0;
        tbl_raddr  = {r_dec2[IDX_W-1:0], c_dec[IDX_W-1:0]};
        ans_we     = 1'b0;
        ans_waddr  = pos_dec[IDX_W-1:0];
        ans_re     = 1'b0;
        ans_raddr  = k_reg[IDX_W-1:0];
        emit       = '0;
        done       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    r_next     = CNT_W'(1);
                    c_next     = CNT_W'(1);
                    total_next = '0;
                    pos_next   = '0;
                    k_next     = '0;
                    if (len_a == '0 || len_b == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                // Row symbol is held in the read register for the whole row.
                s1_re      = 1'b1;
                left_next  = '0;
                diag_next  = '0;
                c_next     = CNT_W'(1);
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                s2_re      = 1'b1;
                tbl_re     = 1'b1;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                tbl_we    = 1'b1;
                diag_next = up_val;
                left_next = cell_val;
                if (c_reg == len_b) begin
                    if (r_reg == len_a) begin
                        total_next = cell_val;
                        pos_next   = cell_val;
                        state_next = ST_TB_RD;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_ROW;
                    end
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_FILL_RD;
                end
            end
            ST_TB_RD: begin
                s1_re      = 1'b1;
                s2_re      = 1'b1;
                tbl_re     = 1'b1;
                state_next = ST_TB_CHK;
            end
            ST_TB_CHK: begin
                if (match) begin
                    if (pos_reg != '0) begin
                        ans_we   = 1'b1;
                        pos_next = pos_dec;
                    end
                    r_next = r_dec;
                    c_next = c_dec;
                    if (first_row || first_col) begin
                        state_next = (total_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                    end else begin
                        state_next = ST_TB_RD;
                    end
                end else begin
                    // Cell above is in hand; fetch the cell to the left.
                    up_next    = up_val;
                    tbl_re     = 1'b1;
                    tbl_raddr  = {r_dec[IDX_W-1:0], c_dec2[IDX_W-1:0]};
                    state_next = ST_TB_LEFT;
                end
            end
            ST_TB_LEFT: begin
                if (up_reg > left_val) begin
                    r_next = r_dec;
                    if (first_row) begin
                        state_next = (total_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                    end else begin
                        state_next = ST_TB_RD;
                    end
                end else begin
                    c_next = c_dec;
                    if (first_col) begin
                        state_next = (total_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                    end else begin
                        state_next = ST_TB_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                ans_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                emit.valid      = 1'b1;
                emit.symbol     = OUT_SYM_W'(ans_rdata);
                emit.has_symbol = 1'b1;
                emit.length     = OUT_LEN_W'(total_reg);
                emit.last       = (k_inc == total_reg);
                if (emit_ready) begin
                    if (k_inc == total_reg) begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMPTY: begin
                emit.valid = 1'b1;
                emit.last  = 1'b1;
                if (emit_ready) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/longest_common_subsequence.sv
// Longest common subsequence block: string loading, result register, engine.
//
// Input stream: s_tuser carries the command (0 append to first string,
// 1 append to second string, 2 run, 3 ignored), s_tdata the symbol.
// Appends are accepted back to back while idle.
// An append to a full string is dropped and sets the truncated flag.
// A run drops s_tready until its last result has been handed to the
// output register. The table fill reads and then writes each cell, as
// the table memory has a single read port; the traceback walks back
// from the corner; each result is read from memory and then offered.
// An empty answer gives one result with tuser low. Results sit in an
// output register, so a stalled receiver only holds the engine, never
// drops a transfer. After the last result both strings are empty and
// the truncated flag is clear. Reset (aresetn low, synchronous) empties
// both strings, clears the flag and drops m_tvalid; string and table
// memory contents are not cleared and need no clearing pass.
`include "longest_common_subsequence_defines.svh"

module longest_common_subsequence
    import lcs_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] out_symbol, [14:8] lcs_length, [15] truncated
    output logic                m_tuser,   // [0] has_symbol
    output logic                m_tlast
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SYM_W = (SYMBOL_BITS < OUT_SYM_W) ? SYMBOL_BITS : OUT_SYM_W;

    lcs_cmd_t         cmd;
    logic             s_xfer;
    logic             busy_reg, busy_next;
    logic             overflow_reg, overflow_next;
    logic [CNT_W-1:0] len_a_reg, len_a_next;
    logic [CNT_W-1:0] len_b_reg, len_b_next;
    logic             we_a, we_b, start;

    logic             s1_re, s2_re;
    logic [IDX_W-1:0] s1_raddr, s2_raddr;
    logic [SYM_W-1:0] s1_rdata, s2_rdata;

    lcs_emit_t        emit;
    logic             emit_ready, eng_done;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  m_tuser_reg, m_tlast_reg;

    assign cmd      = lcs_cmd_t'(s_tuser);
    assign s_tready = !busy_reg;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        busy_next     = busy_reg;
        overflow_next = overflow_reg;
        len_a_next    = len_a_reg;
        len_b_next    = len_b_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;
        start         = 1'b0;
        if (s_xfer) begin
            case (cmd)
                CMD_LOAD_A: begin
                    if (len_a_reg < CNT_W'(MAX_LEN)) begin
                        we_a       = 1'b1;
                        len_a_next = len_a_reg + 1'b1;
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                CMD_LOAD_B: begin
                    if (len_b_reg < CNT_W'(MAX_LEN)) begin
                        we_b       = 1'b1;
                        len_b_next = len_b_reg + 1'b1;
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                CMD_RUN: begin
                    start     = 1'b1;
                    busy_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (eng_done) begin
            busy_next     = 1'b0;
            overflow_next = 1'b0;
            len_a_next    = '0;
            len_b_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            overflow_reg <= 1'b0;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
        end else begin
            busy_reg     <= busy_next;
            overflow_reg <= overflow_next;
            len_a_reg    <= len_a_next;
            len_b_reg    <= len_b_next;
        end
    end

    lcs_ram #(
        .WIDTH (SYM_W),
        .DEPTH (1 << IDX_W)
    ) u_first (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (len_a_reg[IDX_W-1:0]),
        .wdata (s_tdata[SYM_W-1:0]),
        .re    (s1_re),
        .raddr (s1_raddr),
        .rdata (s1_rdata)
    );

    lcs_ram #(
        .WIDTH (SYM_W),
        .DEPTH (1 << IDX_W)
    ) u_second (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (len_b_reg[IDX_W-1:0]),
        .wdata (s_tdata[SYM_W-1:0]),
        .re    (s2_re),
        .raddr (s2_raddr),
        .rdata (s2_rdata)
    );

    lcs_engine #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .len_a      (len_a_reg),
        .len_b      (len_b_reg),
        .s1_re      (s1_re),
        .s1_raddr   (s1_raddr),
        .s1_rdata   (s1_rdata),
        .s2_re      (s2_re),
        .s2_raddr   (s2_raddr),
        .s2_rdata   (s2_rdata),
        .emit       (emit),
        .emit_ready (emit_ready),
        .done       (eng_done)
    );

    // Output register takes a new result when empty or being drained.
    assign emit_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (emit.valid && emit_ready) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid && emit_ready) begin
            m_tdata_reg <= {overflow_reg, emit.length, emit.symbol};
            m_tuser_reg <= emit.has_symbol;
            m_tlast_reg <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `LCS_ASSERT_IMPL(a_len_bound, 1'b1, len_a_reg <= CNT_W'(MAX_LEN) && len_b_reg <= CNT_W'(MAX_LEN), "string length out of range")
    `LCS_ASSERT_IMPL(a_emit_busy, emit.valid, busy_reg, "result offered while no run is active")
    `LCS_ASSERT_NEXT(a_run_busy, s_xfer && cmd == CMD_RUN, busy_reg && !s_tready, "run did not block input")
    `LCS_ASSERT_NEXT(a_full_flags, s_xfer && cmd == CMD_LOAD_A && len_a_reg == CNT_W'(MAX_LEN), overflow_reg, "dropped append did not set truncated")
    `LCS_ASSERT_NEXT(a_done_clears, eng_done, len_a_reg == '0 && len_b_reg == '0 && !overflow_reg && !busy_reg, "run end did not clear state")

endmodule

### dv/longest_common_subsequence_checker.sv
// Checker for the longest common subsequence block: predicts answers and compares results.
module longest_common_subsequence_checker
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser,
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [OUT_SYM_W-1:0] symbol;
        logic                 has_symbol;
        logic [OUT_LEN_W-1:0] length;
        logic                 truncated;
        logic                 last;
    } lcs_result_t;

    logic [OUT_SYM_W-1:0] first_syms  [MAX_LEN];
    logic [OUT_SYM_W-1:0] second_syms [MAX_LEN];
    logic [OUT_SYM_W-1:0] answer_syms [MAX_LEN];
    logic [OUT_LEN_W-1:0] dp_len [MAX_LEN+1][MAX_LEN+1];
    int                   first_len;
    int                   second_len;
    bit                   truncated_flag;
    lcs_result_t          lcs_answer_q[$];

    // Fill the length table, walk back from the corner, queue the answer.
    task automatic solve_lcs();
        int r;
        int c;
        int total;
        int pos;
        lcs_result_t res;
        for (r = 0; r <= first_len; r++) dp_len[r][0] = '0;
        for (c = 0; c <= second_len; c++) dp_len[0][c] = '0;
        for (r = 1; r <= first_len; r++) begin
            for (c = 1; c <= second_len; c++) begin
                if (first_syms[r-1] == second_syms[c-1]) begin
                    dp_len[r][c] = dp_len[r-1][c-1] + 1'b1;
                end else if (dp_len[r-1][c] > dp_len[r][c-1]) begin
                    dp_len[r][c] = dp_len[r-1][c];
                end else begin
                    dp_len[r][c] = dp_len[r][c-1];
                end
            end
        end
        total = dp_len[first_len][second_len];
        pos = total;
        r = first_len;
        c = second_len;
        while (r > 0 && c > 0) begin
            if (first_syms[r-1] == second_syms[c-1]) begin
                if (pos > 0) begin
                    pos--;
                    answer_syms[pos] = first_syms[r-1];
                end
                r--;
                c--;
            end else if (dp_len[r-1][c] > dp_len[r][c-1]) begin
                r--;
            end else begin
                // ties step left
                c--;
            end
        end
        if (total == 0) begin
            res = '{symbol: '0, has_symbol: 1'b0, length: '0,
                    truncated: truncated_flag, last: 1'b1};
            lcs_answer_q.push_back(res);
        end else begin
            for (int k = 0; k < total; k++) begin
                res = '{symbol: answer_syms[k], has_symbol: 1'b1,
                        length: OUT_LEN_W'(total), truncated: truncated_flag,
                        last: (k + 1 == total)};
                lcs_answer_q.push_back(res);
            end
        end
        first_len = 0;
        second_len = 0;
        truncated_flag = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        lcs_result_t want;
        if (!aresetn) begin
            first_len = 0;
            second_len = 0;
            truncated_flag = 1'b0;
            lcs_answer_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_LOAD_A: begin
                        if (first_len < MAX_LEN) begin
                            first_syms[first_len] = s_tdata[OUT_SYM_W-1:0];
                            first_len++;
                        end else begin
                            truncated_flag = 1'b1;
                        end
                    end
                    CMD_LOAD_B: begin
                        if (second_len < MAX_LEN) begin
                            second_syms[second_len] = s_tdata[OUT_SYM_W-1:0];
                            second_len++;
                        end else begin
                            truncated_flag = 1'b1;
                        end
                    end
                    CMD_RUN: solve_lcs();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (lcs_answer_q.size() == 0) begin
                    $error("unexpected result transfer: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = lcs_answer_q.pop_front();
                    check_field("out_symbol", 16'(want.symbol), 16'(m_tdata[7:0]));
                    check_field("has_symbol", 16'(want.has_symbol), 16'(m_tuser));
                    check_field("lcs_length", 16'(want.length), 16'(m_tdata[14:8]));
                    check_field("truncated", 16'(want.truncated), 16'(m_tdata[15]));
                    check_field("is_last", 16'(want.last), 16'(m_tlast));
                end
            end
        end
        pending = lcs_answer_q.size();
    end

endmodule

### dv/longest_common_subsequence_tb.sv
// Testbench top for the longest common subsequence block: stimulus and verdict.
module longest_common_subsequence_tb;
    import lcs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT = 40000;
    localparam int RX_HOLD_CYCLES = 400;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]    s_tuser = CMD_NOP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int fail_count;
    int pending;

    int sent_items;
    int idle_cycles;
    int tx_gap_max = 17;
    int rx_gap_max = 17;
    bit rx_hold_req;
    logic [7:0] first_q[$];
    logic [7:0] second_q[$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    longest_common_subsequence i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    longest_common_subsequence_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Returns at the edge where the item is taken; valid stays up for a back-to-back next item.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] sym);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    // Loads both queued strings interleaved at random, then optionally runs.
    task automatic send_strings(input bit do_run, input bit noisy);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < first_q.size() || ib < second_q.size()) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(CMD_NOP, 8'($urandom));
            if (ib >= second_q.size() || (ia < first_q.size() && $urandom_range(0, 1))) begin
                send_item(CMD_LOAD_A, first_q[ia]);
                ia++;
            end else begin
                send_item(CMD_LOAD_B, second_q[ib]);
                ib++;
            end
        end
        if (do_run) send_item(CMD_RUN, 8'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    // Result side: a random hold-off before each transfer, one long hold on request.
    initial begin
        wait (aresetn);
        forever begin
            int hold;
            if (rx_hold_req) begin
                // long hold starts once a result is waiting in the output register
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                hold = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                hold = $urandom_range(0, rx_gap_max);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("longest_common_subsequence: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int case_idx;
        int n;
        int m;
        logic [7:0] base;
        logic [7:0] mask;
        logic [7:0] sym;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty strings, ignored command, single symbols, one side empty,
        // a tie in the traceback, repeated symbols
        first_q = {};            second_q = {};            send_strings(1, 0);
        send_item(CMD_NOP, 8'hFF);
        first_q = '{8'h00};      second_q = '{8'h00};      send_strings(1, 0);
        first_q = '{8'hFF};      second_q = '{8'hAA};      send_strings(1, 0);
        first_q = '{8'h55};      second_q = {};            send_strings(1, 0);
        first_q = {};            second_q = '{8'h12};      send_strings(1, 0);
        first_q = '{8'h01, 8'h02};         second_q = '{8'h02, 8'h01};  send_strings(1, 0);
        first_q = '{8'h80, 8'h7F, 8'h80};  second_q = '{8'h80, 8'h80};  send_strings(1, 0);

        case_idx = 0;
        while (case_idx == 0 || sent_items < 160) begin
            first_q.delete();
            second_q.delete();
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            // the case right after the long hold keeps offering items
            if (case_idx == 0 || (case_idx > 1 && $urandom_range(0, 3) == 0)) drain_results();
            if (case_idx == 0) begin
                // full-size identical strings with dropped loads on both sides
                tx_gap_max = 0;
                rx_hold_req = 1'b1;
                for (int i = 0; i < MAX_LEN_DEF + 1; i++) begin
                    sym = 8'($urandom);
                    first_q.push_back(sym);
                    second_q.push_back(sym);
                end
                send_strings(1, 0);
            end else begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                m = $urandom_range(0, 8);
                base = 8'($urandom);
                case ($urandom_range(0, 2))
                    0: mask = 8'h01;
                    1: mask = 8'h03;
                    default: mask = 8'hFF;
                endcase
                for (int i = 0; i < n; i++) first_q.push_back(base ^ (8'($urandom) & mask));
                for (int i = 0; i < m; i++) second_q.push_back(base ^ (8'($urandom) & mask));
                // a few cases skip the run so the strings carry over
                send_strings($urandom_range(0, 9) != 0, 1);
            end
            case_idx++;
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("longest_common_subsequence: match");
        end else begin
            $display("longest_common_subsequence: mismatch");
        end
        $finish;
    end

endmodule
